FILE: rtl/core/gsoc_pkg.sv
// Shared constants, register map and control types of the gyro still-offset calibrator.
package gsoc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int OFFSET_BITS     = 16;
  localparam int CNT_W           = 12;
  localparam int TOL_W           = 16;
  localparam int STATUS_W        = 2;
  localparam int SUM_EXTRA       = 13;
  localparam int AXES            = 3;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(64);
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4000);

  // Register index, taken from the word-address bit of paddr.
  localparam logic REG_TOL   = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PRIMED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACCUM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MOTION = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd3;

  typedef struct packed {
    logic capture;    // latch the accepted sample
    logic commit;     // apply the evaluated sample to the run state
    logic load_eval;  // load the result word from the evaluation
    logic div_step;   // advance the dividers by one quotient bit
    logic load_div;   // load the result word from the quotients
  } gsoc_cmd_t;

  typedef struct packed {
    logic run_done;   // the held sample completes a run
  } gsoc_stat_t;

endpackage

FILE: rtl/core/gsoc_regs.sv
// APB register block: motion tolerance and sample count.
module gsoc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gsoc_pkg::ADDR_W-1:0]  paddr,
  input  logic [gsoc_pkg::DATA_W-1:0]  pwdata,
  output logic [gsoc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [gsoc_pkg::TOL_W-1:0]   motion_tolerance,
  output logic [gsoc_pkg::CNT_W-1:0]   sample_count
);
  import gsoc_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_tolerance <= TOL_RESET;
      sample_count     <= COUNT_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_TOL:   motion_tolerance <= pwdata[TOL_W-1:0];
        REG_COUNT: sample_count     <= pwdata[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOL:   prdata = DATA_W'(motion_tolerance);
      REG_COUNT: prdata = DATA_W'(sample_count);
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/gsoc_ctrl.sv
// Controller: sequences capture, evaluation, division and the output register.
module gsoc_ctrl #(
  parameter int SUM_BITS = gsoc_pkg::SAMPLE_BITS_DEF + gsoc_pkg::SUM_EXTRA
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  gsoc_pkg::gsoc_stat_t   stat,
  output gsoc_pkg::gsoc_cmd_t    cmd
);
  import gsoc_pkg::*;

  localparam int DIV_CNT_W = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_BITS - 1);

  typedef enum logic [1:0] {
    IDLE,
    EVAL,
    DIV,
    FIN
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: cmd.capture = s_tvalid;
      EVAL: begin
        if (stat.run_done) begin
          cmd.commit = 1'b1;
        end else if (out_free) begin
          cmd.commit    = 1'b1;
          cmd.load_eval = 1'b1;
        end
      end
      DIV: cmd.div_step = 1'b1;
      FIN: cmd.load_div = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      div_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load_eval || cmd.load_div) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= EVAL;
          end
        end
        EVAL: begin
          if (stat.run_done) begin
            div_cnt <= '0;
            state   <= DIV;
          end else if (out_free) begin
            state <= IDLE;
          end
        end
        DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            state <= FIN;
          end
        end
        FIN: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/gsoc_dp.sv
// Datapath: sample hold, motion test, running sums, restoring dividers and result word.
module gsoc_dp #(
  parameter int SAMPLE_BITS = gsoc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [3*SAMPLE_BITS-1:0]              sample_in,
  input  logic [gsoc_pkg::TOL_W-1:0]            motion_tolerance,
  input  logic [gsoc_pkg::CNT_W-1:0]            sample_count,
  input  gsoc_pkg::gsoc_cmd_t                   cmd,
  output gsoc_pkg::gsoc_stat_t                  stat,
  output logic [gsoc_pkg::STATUS_W-1:0]         status,
  output logic [3*gsoc_pkg::OFFSET_BITS-1:0]    offsets
);
  import gsoc_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + SUM_EXTRA;
  localparam int DIFF_W   = SAMPLE_BITS + 1;
  localparam int CMP_W    = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

  logic signed [SAMPLE_BITS-1:0] samp [AXES];
  logic signed [SAMPLE_BITS-1:0] prev [AXES];
  logic signed [SUM_BITS-1:0]    sum  [AXES];
  logic        [CNT_W-1:0]       remaining;
  logic        [CNT_W-1:0]       run_length;
  logic                          need_prime;

  logic signed [DIFF_W-1:0]      diff    [AXES];
  logic        [DIFF_W-1:0]      mag     [AXES];
  logic signed [SUM_BITS-1:0]    sum_add [AXES];
  logic        [SUM_BITS-1:0]    sum_mag [AXES];
  logic        [AXES-1:0]        axis_moved;
  logic                          moved;
  logic        [CNT_W-1:0]       cnt_n;
  logic        [CNT_W-1:0]       rem_dec;
  logic                          run_done;
  logic        [STATUS_W-1:0]    eval_status;

  // Dividers, one lane per axis: quotient shifts in where the numerator shifts out.
  logic        [SUM_BITS-1:0]    quo     [AXES];
  logic        [CNT_W-1:0]       rem     [AXES];
  logic                          neg     [AXES];
  logic        [CNT_W:0]         trial   [AXES];
  logic                          ge      [AXES];
  logic        [SUM_BITS-1:0]    q_sgn   [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      diff[i]       = DIFF_W'(samp[i]) - DIFF_W'(prev[i]);
      mag[i]        = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
      axis_moved[i] = CMP_W'(mag[i]) > CMP_W'(motion_tolerance);
      sum_add[i]    = sum[i] + SUM_BITS'(samp[i]);
      sum_mag[i]    = sum_add[i][SUM_BITS-1] ? SUM_BITS'(-sum_add[i]) : SUM_BITS'(sum_add[i]);
      trial[i]      = {rem[i], quo[i][SUM_BITS-1]};
      ge[i]         = trial[i] >= {1'b0, run_length};
      q_sgn[i]      = neg[i] ? SUM_BITS'(-quo[i]) : quo[i];
    end
    moved    = |axis_moved;
    cnt_n    = (sample_count == '0) ? CNT_W'(1) : sample_count;
    rem_dec  = (remaining != '0) ? remaining - 1'b1 : '0;
    run_done = !need_prime && !moved && (rem_dec == '0);
    if (need_prime) begin
      eval_status = ST_PRIMED;
    end else if (moved) begin
      eval_status = ST_MOTION;
    end else if (run_done) begin
      eval_status = ST_DONE;
    end else begin
      eval_status = ST_ACCUM;
    end
  end

  assign stat.run_done = run_done;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < AXES; i++) begin
        samp[i] <= sample_in[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  // Run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        prev[i] <= '0;
        sum[i]  <= '0;
      end
      remaining  <= '0;
      run_length <= '0;
      need_prime <= 1'b1;
    end else if (cmd.commit) begin
      if (need_prime) begin
        for (int i = 0; i < AXES; i++) begin
          prev[i] <= samp[i];
          sum[i]  <= '0;
        end
        run_length <= cnt_n;
        remaining  <= cnt_n;
        need_prime <= 1'b0;
      end else if (moved) begin
        need_prime <= 1'b1;
      end else begin
        for (int i = 0; i < AXES; i++) begin
          prev[i] <= samp[i];
          sum[i]  <= sum_add[i];
        end
        remaining <= rem_dec;
        if (run_done) begin
          need_prime <= 1'b1;
        end
      end
    end
  end

  // Restoring division of the sum magnitudes by the latched run length.
  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      if (cmd.commit && run_done) begin
        quo[i] <= sum_mag[i];
        rem[i] <= '0;
        neg[i] <= sum_add[i][SUM_BITS-1];
      end else if (cmd.div_step) begin
        quo[i] <= {quo[i][SUM_BITS-2:0], ge[i]};
        rem[i] <= ge[i] ? CNT_W'(trial[i] - {1'b0, run_length}) : trial[i][CNT_W-1:0];
      end
    end
  end

  // Result word payload.
  always_ff @(posedge clk) begin
    if (cmd.load_eval) begin
      status  <= eval_status;
      offsets <= '0;
    end else if (cmd.load_div) begin
      status <= ST_DONE;
      for (int i = 0; i < AXES; i++) begin
        offsets[i*OFFSET_BITS +: OFFSET_BITS] <= q_sgn[i][OFFSET_BITS-1:0];
      end
    end
  end

endmodule

FILE: rtl/core/gyro_still_offset_calibrator_core.sv
// Top level of the gyro still-offset calibrator: stream ports, APB registers, control and datapath.
//
// Estimates the zero-rate offset of a three-axis gyro. Each input word is one
// sample (x, y, z, two's complement, SAMPLE_BITS each) and gives exactly one
// result word. The first sample of a run primes the previous-sample registers
// and clears the sums (status 0). Each later sample is compared with the
// previous one: if any axis changed by more than motion_tolerance the run is
// dropped (status 2) and the next sample primes again; otherwise the sample is
// summed (status 1). When sample_count still samples have been summed (a count
// of zero acts as one; the count is latched at prime) every sum is divided by
// the count, truncated toward zero, and the offsets go out with status 3;
// offsets read zero for every other status. Sequence: a sample is captured
// into the sample hold register, then evaluated into the result register,
// and no new word is accepted until that is done. A run-completing sample
// also runs the three restoring dividers, one quotient bit per cycle over
// SAMPLE_BITS+13 bits, before its word is loaded. The output register holds
// a finished word while the next sample is taken in.
// Registers (APB, 32-bit data): 0x0 motion_tolerance[15:0] (reset 64),
// 0x4 sample_count[11:0] (reset 4000). Write registers only while idle.
module gyro_still_offset_calibrator_core #(
  parameter int SAMPLE_BITS = gsoc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // rate_x, rate_y, rate_z from bit 0 up, zero-padded to bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // offset_x, offset_y, offset_z from bit 0 up
  output logic [3*gsoc_pkg::OFFSET_BITS-1:0]        m_tdata,
  // status
  output logic [gsoc_pkg::STATUS_W-1:0]             m_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [gsoc_pkg::ADDR_W-1:0]               paddr,
  input  logic [gsoc_pkg::DATA_W-1:0]               pwdata,
  output logic [gsoc_pkg::DATA_W-1:0]               prdata,
  output logic                                      pready
);
  import gsoc_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + SUM_EXTRA;

  logic [TOL_W-1:0] motion_tolerance;
  logic [CNT_W-1:0] sample_count;
  gsoc_cmd_t        cmd;
  gsoc_stat_t       stat;

  // Configuration registers.
  gsoc_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .motion_tolerance (motion_tolerance),
    .sample_count     (sample_count)
  );

  // Sequencer: owns the handshakes and the divider cycle count.
  gsoc_ctrl #(
    .SUM_BITS (SUM_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Sample path, run state, dividers and the result payload register.
  gsoc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .sample_in        (s_tdata[3*SAMPLE_BITS-1:0]),
    .motion_tolerance (motion_tolerance),
    .sample_count     (sample_count),
    .cmd              (cmd),
    .stat             (stat),
    .status           (m_tuser),
    .offsets          (m_tdata)
  );

endmodule

FILE: rtl/core/gsoc_checker.sv
// Port-level checker of the gyro still-offset calibrator, bound to the top level.
module gsoc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [3*gsoc_pkg::OFFSET_BITS-1:0]  m_tdata,
  input logic [gsoc_pkg::STATUS_W-1:0]       m_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [gsoc_pkg::ADDR_W-1:0]         paddr,
  input logic [gsoc_pkg::DATA_W-1:0]         pwdata,
  input logic [gsoc_pkg::DATA_W-1:0]         prdata
);
  import gsoc_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // Offsets are zero unless the word reports a finished calibration.
  a_zero_offsets: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DONE) |-> (m_tdata == '0))
    else $error("nonzero offsets on a word that is not a finished calibration");

  // A sample is worked on alone: no second word right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted in the cycle after an accepted word");

  // A tolerance write reads back.
  a_tol_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (paddr[2] == REG_TOL)) ##1 (paddr[2] == REG_TOL)
      |-> (prdata == DATA_W'($past(pwdata[TOL_W-1:0]))))
    else $error("motion tolerance read back differs from the written value");

endmodule

bind gyro_still_offset_calibrator_core gsoc_checker u_gsoc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

FILE: verif/tb.sv
// Self-checking testbench for the gyro still-offset calibrator core.
`timescale 1ns / 1ps

module tb;
  import gsoc_pkg::*;

  localparam int RATE_W         = SAMPLE_BITS_DEF;
  localparam int SUM_W          = RATE_W + SUM_EXTRA;
  localparam int RATE_MIN       = -(1 << (RATE_W - 1));
  localparam int RATE_MAX       = (1 << (RATE_W - 1)) - 1;
  localparam int TOL_MAX        = (1 << TOL_W) - 1;
  localparam int COUNT_MAX      = (1 << CNT_W) - 1;
  localparam int RAND_ITEMS     = 640;
  localparam int LONG_COUNT     = 255;   // still samples in the full-scale run
  localparam int HOLD_AT        = 200;   // random word at which the sink holds off
  localparam int LONG_AT        = 450;   // random words sent before the full-scale run goes
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;    // covers the divide plus margin
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [ADDR_W-1:0] ADDR_TOL   = {REG_TOL, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_COUNT = {REG_COUNT, 2'b00};

  typedef struct packed {
    logic [STATUS_W-1:0]           status;
    logic signed [OFFSET_BITS-1:0] ox;
    logic signed [OFFSET_BITS-1:0] oy;
    logic signed [OFFSET_BITS-1:0] oz;
  } offset_word_t;

  typedef struct {
    bit           set_regs;
    int           tol;
    int           cnt;
    int           x, y, z;
    bit           typed;
    offset_word_t want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic [3*RATE_W-1:0]      s_tdata = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [3*OFFSET_BITS-1:0] m_tdata;
  logic [STATUS_W-1:0]      m_tuser;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  gyro_still_offset_calibrator_core dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Calibration model state: registers plus the running run.
  logic [TOL_W-1:0]        cfg_tol   = TOL_RESET;
  logic [CNT_W-1:0]        cfg_count = COUNT_RESET;
  logic signed [RATE_W-1:0] last_rate [AXES];
  logic signed [SUM_W-1:0]  rate_sum  [AXES];
  logic [CNT_W-1:0]        left_in_run = '0;
  logic [CNT_W-1:0]        run_div     = '0;
  bit                      prime_next  = 1'b1;

  offset_word_t pending_results[$];
  stim_row_t    stim_rows[$];
  int           last_sent[AXES];
  int           burst_left;
  int           errors;
  int           words_in;
  int           rand_items;
  int           settings_done;
  int           status_seen[4];
  int           idle_cycles;
  bit           hold_req;

  initial begin
    for (int a = 0; a < AXES; a++) begin
      last_rate[a] = '0;
      rate_sum[a]  = '0;
      last_sent[a] = 0;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Advance the calibration model by one sample and return the word it gives out.
  task automatic calib_step(input int x, input int y, input int z, output offset_word_t res);
    logic signed [RATE_W-1:0] cur [AXES];
    logic signed [RATE_W-1:0] avg [AXES];
    bit moved;
    int d;
    cur[0] = RATE_W'(x);
    cur[1] = RATE_W'(y);
    cur[2] = RATE_W'(z);
    moved = 1'b0;
    for (int a = 0; a < AXES; a++) avg[a] = '0;
    res.status = ST_PRIMED;
    if (prime_next) begin
      run_div = (cfg_count == '0) ? CNT_W'(1) : cfg_count;
      left_in_run = run_div;
      for (int a = 0; a < AXES; a++) begin
        last_rate[a] = cur[a];
        rate_sum[a]  = '0;
      end
      prime_next = 1'b0;
    end else begin
      for (int a = 0; a < AXES; a++) begin
        d = int'(cur[a]) - int'(last_rate[a]);
        if (d < 0) d = -d;
        if (d > int'(cfg_tol)) moved = 1'b1;
      end
      if (moved) begin
        prime_next = 1'b1;
        res.status = ST_MOTION;
      end else begin
        for (int a = 0; a < AXES; a++) begin
          rate_sum[a]  = rate_sum[a] + SUM_W'(cur[a]);
          last_rate[a] = cur[a];
        end
        if (left_in_run != '0) left_in_run--;
        if (left_in_run == '0) begin
          // SV integer division truncates toward zero, as the divider does
          for (int a = 0; a < AXES; a++)
            avg[a] = RATE_W'(int'(rate_sum[a]) / int'(run_div));
          prime_next = 1'b1;
          res.status = ST_DONE;
        end else begin
          res.status = ST_ACCUM;
        end
      end
    end
    res.ox = avg[0];
    res.oy = avg[1];
    res.oz = avg[2];
  endtask

  // Write one register with junk in the unused bits, then read it back.
  task automatic reg_write(input logic [ADDR_W-1:0] addr, input int val);
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] mask;
    mask = (addr == ADDR_TOL) ? DATA_W'(TOL_MAX) : DATA_W'(COUNT_MAX);
    word = ($urandom & ~mask) | (DATA_W'(val) & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_TOL) cfg_tol = TOL_W'(val);
    else cfg_count = CNT_W'(val);
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (word & mask))
      report("register readback", longint'(prdata & mask), longint'(word & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the block, let the divider settle, then load both registers.
  task automatic apply_settings(input int tol, input int cnt);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(ADDR_TOL, tol);
    reg_write(ADDR_COUNT, cnt);
    settings_done++;
  endtask

  // Offer one sample word; bursts of random length with random gaps between them.
  task automatic send_sample(input int x, input int y, input int z, input bit typed,
                             input offset_word_t want);
    offset_word_t got;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
    end
    s_tdata  <= {RATE_W'(z), RATE_W'(y), RATE_W'(x)};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    words_in++;
    calib_step(x, y, z, got);
    pending_results.push_back(typed ? want : got);
    last_sent[0] = x;
    last_sent[1] = y;
    last_sent[2] = z;
  endtask

  function automatic int clamp_rate(input int v);
    if (v < RATE_MIN) return RATE_MIN;
    if (v > RATE_MAX) return RATE_MAX;
    return v;
  endfunction

  task automatic add_row(input bit set_regs, input int tol, input int cnt,
                         input int x, input int y, input int z, input bit typed,
                         input logic [STATUS_W-1:0] st, input int ox, input int oy,
                         input int oz);
    stim_row_t r;
    r.set_regs = set_regs;
    r.tol = tol;
    r.cnt = cnt;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.want.status = st;
    r.want.ox = OFFSET_BITS'(ox);
    r.want.oy = OFFSET_BITS'(oy);
    r.want.oz = OFFSET_BITS'(oz);
    stim_rows.push_back(r);
  endtask

  // Check each result word against the oldest expectation.
  always @(posedge clk) begin
    offset_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      status_seen[m_tuser]++;
      if (pending_results.size() == 0) begin
        report("result word with nothing pending, status", longint'(m_tuser), -1);
      end else begin
        w = pending_results.pop_front();
        if (m_tuser !== w.status) report("status", longint'(m_tuser), longint'(w.status));
        if ($signed(m_tdata[15:0]) !== w.ox)
          report("offset_x", longint'($signed(m_tdata[15:0])), longint'(w.ox));
        if ($signed(m_tdata[31:16]) !== w.oy)
          report("offset_y", longint'($signed(m_tdata[31:16])), longint'(w.oy));
        if ($signed(m_tdata[47:32]) !== w.oz)
          report("offset_z", longint'($signed(m_tdata[47:32])), longint'(w.oz));
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words pending",
                 idle_cycles, pending_results.size());
        $display("gyro_still_offset_calibrator_core test failed");
        $finish;
      end
    end
  end

  // Sink side: ready runs, random chatter and stalls; one long hold-off on request.
  initial begin : sink_pattern
    int seg;
    int len;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        seg = $urandom_range(0, 2);
        len = (seg == 2) ? $urandom_range(1, 25) : $urandom_range(5, 60);
        repeat (len) begin
          case (seg)
            0: begin
              m_tready <= 1'b1;
            end
            1: begin
              m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
              m_tready <= 1'b0;
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    offset_word_t none;
    int v[AXES];
    int kind;
    int ax;
    int span;
    int tol;
    int cnt;
    int n;
    bit long_done;
    none = '0;
    long_done = 1'b0;
    errors = 0;
    words_in = 0;
    rand_items = 0;
    settings_done = 0;
    burst_left = 0;
    hold_req = 1'b0;
    for (int s = 0; s < 4; s++) status_seen[s] = 0;

    // Reset defaults: tolerance 64, count 4000.
    add_row(0, 0, 0, RATE_MIN, RATE_MAX, 0, 1, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, RATE_MIN + 64, RATE_MAX - 64, 64, 1, ST_ACCUM, 0, 0, 0);
    add_row(0, 0, 0, RATE_MIN + 129, RATE_MAX - 64, 64, 1, ST_MOTION, 0, 0, 0);
    add_row(0, 0, 0, 5, 5, 5, 1, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 500, 5, 5, 1, ST_MOTION, 0, 0, 0);
    // Widest tolerance, single-sample runs: full-scale swing stays still.
    add_row(1, TOL_MAX, 1, RATE_MIN, RATE_MIN, RATE_MIN, 1, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, RATE_MAX, RATE_MAX, RATE_MAX, 1, ST_DONE, RATE_MAX, RATE_MAX, RATE_MAX);
    add_row(0, 0, 0, 0, 0, 0, 1, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, RATE_MIN, -1, 1, 1, ST_DONE, RATE_MIN, -1, 1);
    // Count of zero acts as one; zero tolerance trips on a one-count change.
    add_row(1, 0, 0, 100, -100, 7, 1, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 100, -100, 7, 1, ST_DONE, 100, -100, 7);
    add_row(0, 0, 0, 1, 1, 1, 1, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 1, 1, 2, 1, ST_MOTION, 0, 0, 0);
    // Change equal to tolerance is still; motion on the completing sample drops the run.
    add_row(1, 10, 3, 0, 0, 0, 1, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 10, -10, 0, 1, ST_ACCUM, 0, 0, 0);
    add_row(0, 0, 0, 20, -20, 5, 1, ST_ACCUM, 0, 0, 0);
    add_row(0, 0, 0, 31, -20, 5, 1, ST_MOTION, 0, 0, 0);
    // Average truncated toward zero on a negative sum.
    add_row(0, 0, 0, 3, 0, 0, 1, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 4, 1, -1, 0, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 5, 2, -2, 0, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 6, 4, -4, 1, ST_DONE, 5, 2, -2);
    // Count rewritten mid-run: the running run keeps its latched count.
    add_row(1, TOL_MAX, 2, 1, 1, 1, 0, ST_PRIMED, 0, 0, 0);
    add_row(1, TOL_MAX, 1, 3, 3, 3, 0, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 5, 5, 5, 0, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, ST_PRIMED, 0, 0, 0);
    add_row(0, 0, 0, 9, 9, 9, 0, ST_PRIMED, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].set_regs) apply_settings(stim_rows[i].tol, stim_rows[i].cnt);
      send_sample(stim_rows[i].x, stim_rows[i].y, stim_rows[i].z, stim_rows[i].typed,
                  stim_rows[i].want);
    end

    while (rand_items < RAND_ITEMS) begin
      if (!long_done && rand_items >= LONG_AT) begin
        // Long run at full-scale rates: large sums through the divider.
        apply_settings(TOL_MAX, LONG_COUNT);
        for (int k = 0; k <= LONG_COUNT; k++)
          send_sample(RATE_MAX, RATE_MIN, int'($signed(RATE_W'($urandom))), 0, none);
        long_done = 1'b1;
      end
      case ($urandom_range(0, 7))
        0: tol = 0;
        1: tol = TOL_MAX;
        2: tol = $urandom_range(0, TOL_MAX);
        default: tol = $urandom_range(1, 300);
      endcase
      case ($urandom_range(0, 9))
        0: cnt = 1;
        1: cnt = 2;
        2: cnt = $urandom_range(0, COUNT_MAX);
        3: cnt = COUNT_MAX;
        default: cnt = $urandom_range(1, 16);
      endcase
      apply_settings(tol, cnt);
      span = int'(cfg_tol);
      n = $urandom_range(30, 90);
      repeat (n) begin
        if (rand_items == HOLD_AT) hold_req = 1'b1;
        kind = $urandom_range(0, 99);
        // mostly small still steps from the last sample; some noise and motion
        for (int a = 0; a < AXES; a++) begin
          if (kind < 6) v[a] = int'($signed(RATE_W'($urandom)));
          else v[a] = clamp_rate(last_sent[a] + int'($urandom_range(0, 2 * span)) - span);
        end
        ax = $urandom_range(0, 2);
        if (kind >= 80 && kind < 90)
          v[ax] = clamp_rate(last_sent[ax] + ($urandom_range(0, 1) ? span : -span));
        else if (kind >= 90)
          v[ax] = clamp_rate(last_sent[ax] + ($urandom_range(0, 1) ? span + 1 : -span - 1));
        send_sample(v[0], v[1], v[2], 0, none);
        rand_items++;
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d sample words across %0d register settings, one long full-scale run",
             words_in, settings_done);
    $display("results: %0d primed, %0d summed, %0d motion restarts, %0d offsets out",
             status_seen[ST_PRIMED], status_seen[ST_ACCUM], status_seen[ST_MOTION],
             status_seen[ST_DONE]);
    if (errors == 0) begin
      $display("gyro_still_offset_calibrator_core test passed");
    end else begin
      $display("gyro_still_offset_calibrator_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/gsoc_pkg.sv
rtl/core/gsoc_regs.sv
rtl/core/gsoc_ctrl.sv
rtl/core/gsoc_dp.sv
rtl/core/gyro_still_offset_calibrator_core.sv
rtl/core/gsoc_checker.sv
verif/tb.sv
